@@ src/mipsdec_pkg.sv @@
// MIPS32 instruction decoder: shared types, encoding constants and operation table.
// Used by mipsdec_decode and mips32_instruction_decoder. No dependencies.
package mipsdec_pkg;

  // Input item: one fetched instruction and its address
  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] fetch_pc;
  } in_t;

  // Result item
  typedef struct packed {
    logic [6:0]  operation;
    logic [1:0]  flow_kind;
    logic [4:0]  first_source_reg;
    logic [4:0]  second_source_reg;
    logic [4:0]  target_reg;
    logic        target_discard;
    logic [2:0]  slot_is_imm;
    logic [31:0] first_source_imm;
    logic [31:0] second_source_imm;
    logic [31:0] target_imm;
  } out_t;

  // Dense operation numbers, table order
  typedef enum logic [6:0] {
    OP_INVALID = 7'd0,
    OP_SLLI, OP_SRLI, OP_SRAI, OP_SLL, OP_SRL, OP_SRA, OP_JR, OP_RET, OP_JALR, OP_MOVZ,
    OP_MOVN, OP_SYSCALL, OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO, OP_MULT, OP_MULTU, OP_DIV,
    OP_DIVU, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU, OP_MUL,
    OP_CLZ, OP_BLTZ, OP_BGEZ, OP_TLBWI, OP_TLBWR, OP_TLBP, OP_ERET, OP_MFC0, OP_MTC0,
    OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_SLTI, OP_SLTUI, OP_ANDI,
    OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
    OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_TRAP
  } op_e;

  // Control-flow kind
  typedef enum logic [1:0] {
    FLOW_NORMAL   = 2'd0,
    FLOW_JUMP     = 2'd1,
    FLOW_BRANCH   = 2'd2,
    FLOW_INDIRECT = 2'd3
  } flow_e;

  // Operand layout of an operation
  typedef enum logic [3:0] {
    F_NONE, F_R, F_SHIFT, F_JALR, F_CMOV, F_B, F_CP0, F_J, F_JAL,
    F_LD, F_ST, F_IU, F_LUI
  } form_e;

  // slot_is_imm masks
  localparam logic [2:0] IMM_NONE  = 3'b000;
  localparam logic [2:0] IMM_FIRST = 3'b001;
  localparam logic [2:0] IMM_SECND = 3'b010;
  localparam logic [2:0] IMM_TARGT = 3'b100;

  // Primary opcodes
  localparam logic [5:0] OPC_SPECIAL  = 6'd0;
  localparam logic [5:0] OPC_REGIMM   = 6'd1;
  localparam logic [5:0] OPC_J        = 6'd2;
  localparam logic [5:0] OPC_JAL      = 6'd3;
  localparam logic [5:0] OPC_BEQ      = 6'd4;
  localparam logic [5:0] OPC_BNE      = 6'd5;
  localparam logic [5:0] OPC_BLEZ     = 6'd6;
  localparam logic [5:0] OPC_BGTZ     = 6'd7;
  localparam logic [5:0] OPC_ADDI     = 6'd9;
  localparam logic [5:0] OPC_SLTI     = 6'd10;
  localparam logic [5:0] OPC_SLTIU    = 6'd11;
  localparam logic [5:0] OPC_ANDI     = 6'd12;
  localparam logic [5:0] OPC_ORI      = 6'd13;
  localparam logic [5:0] OPC_XORI     = 6'd14;
  localparam logic [5:0] OPC_LUI      = 6'd15;
  localparam logic [5:0] OPC_COP0     = 6'o20;
  localparam logic [5:0] OPC_SPECIAL2 = 6'o34;
  localparam logic [5:0] OPC_LB       = 6'd32;
  localparam logic [5:0] OPC_LH       = 6'd33;
  localparam logic [5:0] OPC_LWL      = 6'd34;
  localparam logic [5:0] OPC_LW       = 6'd35;
  localparam logic [5:0] OPC_LBU      = 6'd36;
  localparam logic [5:0] OPC_LHU      = 6'd37;
  localparam logic [5:0] OPC_LWR      = 6'd38;
  localparam logic [5:0] OPC_SB       = 6'd40;
  localparam logic [5:0] OPC_SH       = 6'd41;
  localparam logic [5:0] OPC_SWL      = 6'd42;
  localparam logic [5:0] OPC_SW       = 6'd43;
  localparam logic [5:0] OPC_SWR      = 6'd46;
  localparam logic [5:0] OPC_TRAP     = 6'o74;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_MOVZ    = 6'd10;
  localparam logic [5:0] FN_MOVN    = 6'd11;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  // SPECIAL2 function codes
  localparam logic [5:0] FN2_MUL = 6'd2;
  localparam logic [5:0] FN2_CLZ = 6'd32;

  // COP0 CO-space function codes
  localparam logic [5:0] CO_TLBWI = 6'd2;
  localparam logic [5:0] CO_TLBWR = 6'd6;
  localparam logic [5:0] CO_TLBP  = 6'd8;
  localparam logic [5:0] CO_ERET  = 6'd24;

  // COP0 rs sub-codes and REGIMM rt sub-codes
  localparam logic [4:0] RS_MF   = 5'd0;
  localparam logic [4:0] RS_MT   = 5'd4;
  localparam logic [4:0] RT_BLTZ = 5'd0;
  localparam logic [4:0] RT_BGEZ = 5'd1;

  // Return-address register and the zero register
  localparam logic [4:0] REG_RA = 5'd31;
  localparam logic [4:0] REG_ZERO = 5'd0;

  // Operand layout of each operation; lwl and lwr merge into their target,
  // so they take the store layout
  function automatic form_e op_form(op_e op);
    form_e f;
    unique case (op)
      OP_SLLI, OP_SRLI, OP_SRAI:                          f = F_SHIFT;
      OP_SLL, OP_SRL, OP_SRA, OP_JR, OP_RET,
      OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO, OP_MULT, OP_MULTU,
      OP_DIV, OP_DIVU, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR,
      OP_NOR, OP_SLT, OP_SLTU, OP_MUL, OP_CLZ:            f = F_R;
      OP_JALR:                                            f = F_JALR;
      OP_MOVZ, OP_MOVN:                                   f = F_CMOV;
      OP_BLTZ, OP_BGEZ, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: f = F_B;
      OP_MFC0, OP_MTC0:                                   f = F_CP0;
      OP_J:                                               f = F_J;
      OP_JAL:                                             f = F_JAL;
      OP_ADDI, OP_SLTI, OP_SLTUI, OP_LB, OP_LH,
      OP_LW, OP_LBU, OP_LHU:                              f = F_LD;
      OP_LWL, OP_LWR, OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR: f = F_ST;
      OP_ANDI, OP_ORI, OP_XORI:                           f = F_IU;
      OP_LUI:                                             f = F_LUI;
      default:                                            f = F_NONE;
    endcase
    return f;
  endfunction

endpackage

@@ src/mipsdec_decode.sv @@
// MIPS32 instruction decoder: combinational decode of one instruction word.
// Depends on mipsdec_pkg.
module mipsdec_decode
  import mipsdec_pkg::*;
(
  input  in_t  item_i,
  output out_t result_o
);

  logic [31:0] w, pc;
  logic [5:0]  opc, func;
  logic [4:0]  rs, rt, rd, sa;
  logic [15:0] imm;
  logic [31:0] simm, zimm, jtarget, btarget, link;
  op_e         op, op_spec;
  form_e       form;
  flow_e       flow;
  logic        dst_written;

  // Instruction fields
  assign w    = item_i.instr_word;
  assign pc   = item_i.fetch_pc;
  assign opc  = w[31:26];
  assign rs   = w[25:21];
  assign rt   = w[20:16];
  assign rd   = w[15:11];
  assign sa   = w[10:6];
  assign func = w[5:0];
  assign imm  = w[15:0];

  // Immediates and addresses (wrap modulo 2^32)
  assign simm    = {{16{imm[15]}}, imm};
  assign zimm    = {16'h0000, imm};
  assign jtarget = {pc[31:28], w[25:0], 2'b00};
  assign btarget = pc + 32'd4 + {simm[29:0], 2'b00};
  assign link    = pc + 32'd8;

  // SPECIAL function decode
  always_comb begin
    unique case (func)
      FN_SLL:     op_spec = OP_SLLI;
      FN_SRL:     op_spec = OP_SRLI;
      FN_SRA:     op_spec = OP_SRAI;
      FN_SLLV:    op_spec = OP_SLL;
      FN_SRLV:    op_spec = OP_SRL;
      FN_SRAV:    op_spec = OP_SRA;
      FN_JR:      op_spec = (rs == REG_RA) ? OP_RET : OP_JR;
      FN_JALR:    op_spec = OP_JALR;
      FN_MOVZ:    op_spec = OP_MOVZ;
      FN_MOVN:    op_spec = OP_MOVN;
      FN_SYSCALL: op_spec = OP_SYSCALL;
      FN_MFHI:    op_spec = OP_MFHI;
      FN_MTHI:    op_spec = OP_MTHI;
      FN_MFLO:    op_spec = OP_MFLO;
      FN_MTLO:    op_spec = OP_MTLO;
      FN_MULT:    op_spec = OP_MULT;
      FN_MULTU:   op_spec = OP_MULTU;
      FN_DIV:     op_spec = OP_DIV;
      FN_DIVU:    op_spec = OP_DIVU;
      FN_ADDU:    op_spec = OP_ADD;
      FN_SUBU:    op_spec = OP_SUB;
      FN_AND:     op_spec = OP_AND;
      FN_OR:      op_spec = OP_OR;
      FN_XOR:     op_spec = OP_XOR;
      FN_NOR:     op_spec = OP_NOR;
      FN_SLT:     op_spec = OP_SLT;
      FN_SLTU:    op_spec = OP_SLTU;
      default:    op_spec = OP_INVALID;
    endcase
  end

  // Primary opcode decode
  always_comb begin
    unique case (opc)
      OPC_SPECIAL: op = op_spec;
      OPC_REGIMM:  op = (rt == RT_BLTZ) ? OP_BLTZ : ((rt == RT_BGEZ) ? OP_BGEZ : OP_INVALID);
      OPC_J:       op = OP_J;
      OPC_JAL:     op = OP_JAL;
      OPC_BEQ:     op = OP_BEQ;
      OPC_BNE:     op = OP_BNE;
      OPC_BLEZ:    op = OP_BLEZ;
      OPC_BGTZ:    op = OP_BGTZ;
      OPC_ADDI:    op = OP_ADDI;
      OPC_SLTI:    op = OP_SLTI;
      OPC_SLTIU:   op = OP_SLTUI;
      OPC_ANDI:    op = OP_ANDI;
      OPC_ORI:     op = OP_ORI;
      OPC_XORI:    op = OP_XORI;
      OPC_LUI:     op = OP_LUI;
      OPC_COP0: begin
        if (rs[4]) begin
          unique case (func)
            CO_TLBWI: op = OP_TLBWI;
            CO_TLBWR: op = OP_TLBWR;
            CO_TLBP:  op = OP_TLBP;
            CO_ERET:  op = OP_ERET;
            default:  op = OP_INVALID;
          endcase
        end else begin
          op = (rs == RS_MF) ? OP_MFC0 : ((rs == RS_MT) ? OP_MTC0 : OP_INVALID);
        end
      end
      OPC_SPECIAL2: op = (func == FN2_MUL) ? OP_MUL
                       : ((func == FN2_CLZ) ? OP_CLZ : OP_INVALID);
      OPC_LB:      op = OP_LB;
      OPC_LH:      op = OP_LH;
      OPC_LWL:     op = OP_LWL;
      OPC_LW:      op = OP_LW;
      OPC_LBU:     op = OP_LBU;
      OPC_LHU:     op = OP_LHU;
      OPC_LWR:     op = OP_LWR;
      OPC_SB:      op = OP_SB;
      OPC_SH:      op = OP_SH;
      OPC_SWL:     op = OP_SWL;
      OPC_SW:      op = OP_SW;
      OPC_SWR:     op = OP_SWR;
      OPC_TRAP:    op = OP_TRAP;
      default:     op = OP_INVALID;
    endcase
  end

  assign form = op_form(op);

  // Flow kind
  always_comb begin
    unique case (op)
      OP_JR, OP_RET, OP_JALR:                             flow = FLOW_INDIRECT;
      OP_J, OP_JAL:                                       flow = FLOW_JUMP;
      OP_BLTZ, OP_BGEZ, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: flow = FLOW_BRANCH;
      default:                                            flow = FLOW_NORMAL;
    endcase
  end

  // Operand slots by form; unused slots stay zero
  always_comb begin
    result_o    = '0;
    dst_written = 1'b0;
    result_o.operation = op;
    result_o.flow_kind = flow;
    unique case (form)
      F_R: begin
        result_o.first_source_reg  = rs;
        result_o.second_source_reg = rt;
        result_o.target_reg        = rd;
        dst_written                = 1'b1;
      end
      F_SHIFT: begin
        result_o.first_source_imm  = {27'd0, sa};
        result_o.slot_is_imm       = IMM_FIRST;
        result_o.second_source_reg = rt;
        result_o.target_reg        = rd;
        dst_written                = 1'b1;
      end
      F_JALR: begin
        result_o.first_source_reg  = rs;
        result_o.target_reg        = rd;
        result_o.second_source_imm = link;
        result_o.slot_is_imm       = IMM_SECND;
        dst_written                = 1'b1;
      end
      F_CMOV: begin
        result_o.first_source_reg  = rs;
        result_o.second_source_reg = rt;
        result_o.target_reg        = rd;
      end
      F_B: begin
        result_o.first_source_reg  = rs;
        result_o.second_source_reg = rt;
        result_o.target_imm        = btarget;
        result_o.slot_is_imm       = IMM_TARGT;
      end
      F_CP0: begin
        result_o.second_source_reg = rt;
        result_o.target_imm        = {27'd0, rd};
        result_o.slot_is_imm       = IMM_TARGT;
      end
      F_J: begin
        result_o.target_imm  = jtarget;
        result_o.slot_is_imm = IMM_TARGT;
      end
      F_JAL: begin
        result_o.target_imm        = jtarget;
        result_o.second_source_imm = link;
        result_o.slot_is_imm       = IMM_TARGT | IMM_SECND;
      end
      F_LD: begin
        result_o.first_source_reg  = rs;
        result_o.second_source_imm = simm;
        result_o.slot_is_imm       = IMM_SECND;
        result_o.target_reg        = rt;
        dst_written                = 1'b1;
      end
      F_ST: begin
        result_o.first_source_reg  = rs;
        result_o.second_source_imm = simm;
        result_o.slot_is_imm       = IMM_SECND;
        result_o.target_reg        = rt;
      end
      F_IU: begin
        result_o.first_source_reg  = rs;
        result_o.second_source_imm = zimm;
        result_o.slot_is_imm       = IMM_SECND;
        result_o.target_reg        = rt;
        dst_written                = 1'b1;
      end
      F_LUI: begin
        result_o.first_source_imm = {imm, 16'h0000};
        result_o.slot_is_imm      = IMM_FIRST;
        result_o.target_reg       = rt;
        dst_written               = 1'b1;
      end
      default: begin
      end
    endcase
    result_o.target_discard = dst_written && (result_o.target_reg == REG_ZERO);
  end

endmodule

@@ src/mips32_instruction_decoder.sv @@
// MIPS32 instruction decoder top level: input register, decode, result register.
// Depends on mipsdec_pkg and mipsdec_decode.
//
//  channel  | ports                      | transfer when
//  ---------+----------------------------+------------------------------
//  item in  | start_i, busy_o, item_i    | start_i high and busy_o low
//  result   | valid_o, result_o          | valid_o high (one cycle)
//
// One instruction per cycle; busy_o is never raised.
// An instruction passes through the input register, then is decoded into the result register.
// Reset (rst_ni low, asynchronous) clears both valid flags; payload is not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module mips32_instruction_decoder
  import mipsdec_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_t  item_i,
  output logic valid_o,
  output out_t result_o
);

  logic in_valid_q, in_valid_d;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q, out_d;

  // Decoder never stalls
  assign busy_o     = 1'b0;
  assign in_valid_d = start_i && !busy_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_d) begin
      in_q <= item_i;
    end
  end

  // Decode
  mipsdec_decode u_decode (
    .item_i   (in_q),
    .result_o (out_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_q;

  // Checks
  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |=> valid_o)
    else $error("decoded item lost between stages");

  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.operation == OP_INVALID) |->
      (result_o.flow_kind == FLOW_NORMAL && result_o.slot_is_imm == IMM_NONE &&
       result_o.target_discard == 1'b0))
    else $error("invalid encoding carries operands");

  a_discard_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.target_discard) |->
      (result_o.target_reg == REG_ZERO && !result_o.slot_is_imm[2]))
    else $error("discard flag without r0 destination");

  a_jump_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (result_o.flow_kind == FLOW_JUMP || result_o.flow_kind == FLOW_BRANCH)) |->
      result_o.slot_is_imm[2])
    else $error("jump or branch without target immediate");

  a_ret_ra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.operation == OP_RET) |-> result_o.first_source_reg == REG_RA)
    else $error("ret decoded without ra source");

endmodule

@@ sim/mips32_instruction_decoder_tb.sv @@
// Self-checking testbench for mips32_instruction_decoder: directed and random instruction streams.
// Compares each decoded result with an in-bench predictor.
// Depends on mipsdec_pkg and the decoder RTL.
module mips32_instruction_decoder_tb;
  import mipsdec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1800;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_t  item_i;
  logic valid_o;
  out_t result_o;

  out_t expected_decodes[$];
  int   mismatch_count;
  int   burst_left;

  mips32_instruction_decoder u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .item_i   (item_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // Clock, 4 ns period
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Decode one instruction word the way the block should
  function automatic out_t predict_decode(in_t it);
    logic [31:0] w, pc, simm, zimm;
    logic [4:0]  rs, rt, rd, sa;
    logic [5:0]  opc, fn;
    op_e         op;
    form_e       form;
    logic        writes;
    out_t        r;
    w    = it.instr_word;
    pc   = it.fetch_pc;
    opc  = w[31:26];
    rs   = w[25:21];
    rt   = w[20:16];
    rd   = w[15:11];
    sa   = w[10:6];
    fn   = w[5:0];
    simm = {{16{w[15]}}, w[15:0]};
    zimm = {16'h0000, w[15:0]};
    op   = OP_INVALID;

    // Operation lookup
    case (opc)
      OPC_SPECIAL: begin
        case (fn)
          FN_SLL:     op = OP_SLLI;
          FN_SRL:     op = OP_SRLI;
          FN_SRA:     op = OP_SRAI;
          FN_SLLV:    op = OP_SLL;
          FN_SRLV:    op = OP_SRL;
          FN_SRAV:    op = OP_SRA;
          FN_JR:      op = (rs == REG_RA) ? OP_RET : OP_JR;
          FN_JALR:    op = OP_JALR;
          FN_MOVZ:    op = OP_MOVZ;
          FN_MOVN:    op = OP_MOVN;
          FN_SYSCALL: op = OP_SYSCALL;
          FN_MFHI:    op = OP_MFHI;
          FN_MTHI:    op = OP_MTHI;
          FN_MFLO:    op = OP_MFLO;
          FN_MTLO:    op = OP_MTLO;
          FN_MULT:    op = OP_MULT;
          FN_MULTU:   op = OP_MULTU;
          FN_DIV:     op = OP_DIV;
          FN_DIVU:    op = OP_DIVU;
          FN_ADDU:    op = OP_ADD;
          FN_SUBU:    op = OP_SUB;
          FN_AND:     op = OP_AND;
          FN_OR:      op = OP_OR;
          FN_XOR:     op = OP_XOR;
          FN_NOR:     op = OP_NOR;
          FN_SLT:     op = OP_SLT;
          FN_SLTU:    op = OP_SLTU;
          default:    op = OP_INVALID;
        endcase
      end
      OPC_REGIMM: begin
        if (rt == RT_BLTZ) op = OP_BLTZ;
        else if (rt == RT_BGEZ) op = OP_BGEZ;
      end
      OPC_J:     op = OP_J;
      OPC_JAL:   op = OP_JAL;
      OPC_BEQ:   op = OP_BEQ;
      OPC_BNE:   op = OP_BNE;
      OPC_BLEZ:  op = OP_BLEZ;
      OPC_BGTZ:  op = OP_BGTZ;
      OPC_ADDI:  op = OP_ADDI;
      OPC_SLTI:  op = OP_SLTI;
      OPC_SLTIU: op = OP_SLTUI;
      OPC_ANDI:  op = OP_ANDI;
      OPC_ORI:   op = OP_ORI;
      OPC_XORI:  op = OP_XORI;
      OPC_LUI:   op = OP_LUI;
      OPC_COP0: begin
        if (rs[4]) begin
          case (fn)
            CO_TLBWI: op = OP_TLBWI;
            CO_TLBWR: op = OP_TLBWR;
            CO_TLBP:  op = OP_TLBP;
            CO_ERET:  op = OP_ERET;
            default:  op = OP_INVALID;
          endcase
        end else if (rs == RS_MF) begin
          op = OP_MFC0;
        end else if (rs == RS_MT) begin
          op = OP_MTC0;
        end
      end
      OPC_SPECIAL2: begin
        if (fn == FN2_MUL) op = OP_MUL;
        else if (fn == FN2_CLZ) op = OP_CLZ;
      end
      OPC_LB:    op = OP_LB;
      OPC_LH:    op = OP_LH;
      OPC_LWL:   op = OP_LWL;
      OPC_LW:    op = OP_LW;
      OPC_LBU:   op = OP_LBU;
      OPC_LHU:   op = OP_LHU;
      OPC_LWR:   op = OP_LWR;
      OPC_SB:    op = OP_SB;
      OPC_SH:    op = OP_SH;
      OPC_SWL:   op = OP_SWL;
      OPC_SW:    op = OP_SW;
      OPC_SWR:   op = OP_SWR;
      OPC_TRAP:  op = OP_TRAP;
      default:   op = OP_INVALID;
    endcase

    // Operand layout; lwl and lwr merge into their target, so they take the store layout
    case (op)
      OP_SLLI, OP_SRLI, OP_SRAI:                          form = F_SHIFT;
      OP_SLL, OP_SRL, OP_SRA, OP_JR, OP_RET,
      OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO, OP_MULT, OP_MULTU,
      OP_DIV, OP_DIVU, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR,
      OP_NOR, OP_SLT, OP_SLTU, OP_MUL, OP_CLZ:            form = F_R;
      OP_JALR:                                            form = F_JALR;
      OP_MOVZ, OP_MOVN:                                   form = F_CMOV;
      OP_BLTZ, OP_BGEZ, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: form = F_B;
      OP_MFC0, OP_MTC0:                                   form = F_CP0;
      OP_J:                                               form = F_J;
      OP_JAL:                                             form = F_JAL;
      OP_ADDI, OP_SLTI, OP_SLTUI, OP_LB, OP_LH,
      OP_LW, OP_LBU, OP_LHU:                              form = F_LD;
      OP_LWL, OP_LWR, OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR: form = F_ST;
      OP_ANDI, OP_ORI, OP_XORI:                           form = F_IU;
      OP_LUI:                                             form = F_LUI;
      default:                                            form = F_NONE;
    endcase

    // Fill the slots; unused fields stay zero
    r = '0;
    writes = 1'b0;
    r.operation = op;
    case (form)
      F_R: begin
        r.first_source_reg = rs; r.second_source_reg = rt; r.target_reg = rd; writes = 1'b1;
      end
      F_SHIFT: begin
        r.first_source_imm = {27'd0, sa}; r.slot_is_imm = IMM_FIRST;
        r.second_source_reg = rt; r.target_reg = rd; writes = 1'b1;
      end
      F_JALR: begin
        r.first_source_reg = rs; r.target_reg = rd; writes = 1'b1;
        r.second_source_imm = pc + 32'd8; r.slot_is_imm = IMM_SECND;
      end
      F_CMOV: begin
        r.first_source_reg = rs; r.second_source_reg = rt; r.target_reg = rd;
      end
      F_B: begin
        r.first_source_reg = rs; r.second_source_reg = rt;
        r.target_imm = pc + 32'd4 + (simm << 2); r.slot_is_imm = IMM_TARGT;
      end
      F_CP0: begin
        r.second_source_reg = rt; r.target_imm = {27'd0, rd}; r.slot_is_imm = IMM_TARGT;
      end
      F_J: begin
        r.target_imm = {pc[31:28], w[25:0], 2'b00}; r.slot_is_imm = IMM_TARGT;
      end
      F_JAL: begin
        r.target_imm = {pc[31:28], w[25:0], 2'b00};
        r.second_source_imm = pc + 32'd8; r.slot_is_imm = IMM_SECND | IMM_TARGT;
      end
      F_LD: begin
        r.first_source_reg = rs; r.second_source_imm = simm; r.slot_is_imm = IMM_SECND;
        r.target_reg = rt; writes = 1'b1;
      end
      F_ST: begin
        r.first_source_reg = rs; r.second_source_imm = simm; r.slot_is_imm = IMM_SECND;
        r.target_reg = rt;
      end
      F_IU: begin
        r.first_source_reg = rs; r.second_source_imm = zimm; r.slot_is_imm = IMM_SECND;
        r.target_reg = rt; writes = 1'b1;
      end
      F_LUI: begin
        r.first_source_imm = {w[15:0], 16'h0000}; r.slot_is_imm = IMM_FIRST;
        r.target_reg = rt; writes = 1'b1;
      end
      default: ;
    endcase
    r.target_discard = writes && (r.target_reg == REG_ZERO);

    // Control-flow kind
    case (op)
      OP_JR, OP_RET, OP_JALR:                              r.flow_kind = FLOW_INDIRECT;
      OP_J, OP_JAL:                                        r.flow_kind = FLOW_JUMP;
      OP_BLTZ, OP_BGEZ, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ:  r.flow_kind = FLOW_BRANCH;
      default:                                             r.flow_kind = FLOW_NORMAL;
    endcase
    return r;
  endfunction

  // Build a well-formed word for an operation; the free fields are random
  function automatic logic [31:0] encode_op(op_e op);
    logic [31:0] w;
    logic [5:0]  opc, fn;
    logic        has_fn;
    w = $urandom;
    opc = OPC_SPECIAL;
    fn = w[5:0];
    has_fn = 1'b1;
    case (op)
      OP_SLLI:    fn = FN_SLL;
      OP_SRLI:    fn = FN_SRL;
      OP_SRAI:    fn = FN_SRA;
      OP_SLL:     fn = FN_SLLV;
      OP_SRL:     fn = FN_SRLV;
      OP_SRA:     fn = FN_SRAV;
      OP_JR,
      OP_RET:     fn = FN_JR;
      OP_JALR:    fn = FN_JALR;
      OP_MOVZ:    fn = FN_MOVZ;
      OP_MOVN:    fn = FN_MOVN;
      OP_SYSCALL: fn = FN_SYSCALL;
      OP_MFHI:    fn = FN_MFHI;
      OP_MTHI:    fn = FN_MTHI;
      OP_MFLO:    fn = FN_MFLO;
      OP_MTLO:    fn = FN_MTLO;
      OP_MULT:    fn = FN_MULT;
      OP_MULTU:   fn = FN_MULTU;
      OP_DIV:     fn = FN_DIV;
      OP_DIVU:    fn = FN_DIVU;
      OP_ADD:     fn = FN_ADDU;
      OP_SUB:     fn = FN_SUBU;
      OP_AND:     fn = FN_AND;
      OP_OR:      fn = FN_OR;
      OP_XOR:     fn = FN_XOR;
      OP_NOR:     fn = FN_NOR;
      OP_SLT:     fn = FN_SLT;
      OP_SLTU:    fn = FN_SLTU;
      OP_MUL:     begin opc = OPC_SPECIAL2; fn = FN2_MUL; end
      OP_CLZ:     begin opc = OPC_SPECIAL2; fn = FN2_CLZ; end
      OP_TLBWI:   begin opc = OPC_COP0; fn = CO_TLBWI; end
      OP_TLBWR:   begin opc = OPC_COP0; fn = CO_TLBWR; end
      OP_TLBP:    begin opc = OPC_COP0; fn = CO_TLBP; end
      OP_ERET:    begin opc = OPC_COP0; fn = CO_ERET; end
      default:    has_fn = 1'b0;
    endcase
    if (has_fn) w = {opc, w[25:6], fn};

    // Sub-code fix-ups and the opcode-only forms
    case (op)
      OP_JR:   if (w[25:21] == REG_RA) w[25:21] = REG_RA - 5'd1;
      OP_RET:  w[25:21] = REG_RA;
      OP_TLBWI, OP_TLBWR, OP_TLBP, OP_ERET: w[25] = 1'b1;
      OP_BLTZ: w = {OPC_REGIMM, w[25:21], RT_BLTZ, w[15:0]};
      OP_BGEZ: w = {OPC_REGIMM, w[25:21], RT_BGEZ, w[15:0]};
      OP_MFC0: w = {OPC_COP0, RS_MF, w[20:0]};
      OP_MTC0: w = {OPC_COP0, RS_MT, w[20:0]};
      OP_J:     w[31:26] = OPC_J;
      OP_JAL:   w[31:26] = OPC_JAL;
      OP_BEQ:   w[31:26] = OPC_BEQ;
      OP_BNE:   w[31:26] = OPC_BNE;
      OP_BLEZ:  w[31:26] = OPC_BLEZ;
      OP_BGTZ:  w[31:26] = OPC_BGTZ;
      OP_ADDI:  w[31:26] = OPC_ADDI;
      OP_SLTI:  w[31:26] = OPC_SLTI;
      OP_SLTUI: w[31:26] = OPC_SLTIU;
      OP_ANDI:  w[31:26] = OPC_ANDI;
      OP_ORI:   w[31:26] = OPC_ORI;
      OP_XORI:  w[31:26] = OPC_XORI;
      OP_LUI:   w[31:26] = OPC_LUI;
      OP_LB:    w[31:26] = OPC_LB;
      OP_LH:    w[31:26] = OPC_LH;
      OP_LWL:   w[31:26] = OPC_LWL;
      OP_LW:    w[31:26] = OPC_LW;
      OP_LBU:   w[31:26] = OPC_LBU;
      OP_LHU:   w[31:26] = OPC_LHU;
      OP_LWR:   w[31:26] = OPC_LWR;
      OP_SB:    w[31:26] = OPC_SB;
      OP_SH:    w[31:26] = OPC_SH;
      OP_SWL:   w[31:26] = OPC_SWL;
      OP_SW:    w[31:26] = OPC_SW;
      OP_SWR:   w[31:26] = OPC_SWR;
      OP_TRAP:  w[31:26] = OPC_TRAP;
      default: ;
    endcase
    return w;
  endfunction

  // Fetch address: mostly random, with the bottom, the wrap edge and the 0xF000_0000 region edge often
  function automatic logic [31:0] pick_pc();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000 + $urandom_range(0, 15);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2:       return {4'hF, 28'h0} - $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  // Sender gap: long idle-free bursts now and then, otherwise mostly short gaps
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One input transfer, then a random gap
  task automatic issue_instr(input logic [31:0] word, input logic [31:0] pc);
    in_t it;
    int  gap;
    it.instr_word = word;
    it.fetch_pc   = pc;
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expected_decodes.push_back(predict_decode(it));
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every strobed result against the oldest prediction
  out_t want_q;
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_decodes.size() == 0) begin
        $error("result transfer with no prediction waiting");
        mismatch_count++;
      end else begin
        want_q = expected_decodes.pop_front();
        check_field("operation", want_q.operation, result_o.operation);
        check_field("flow_kind", want_q.flow_kind, result_o.flow_kind);
        check_field("first_source_reg", want_q.first_source_reg, result_o.first_source_reg);
        check_field("second_source_reg", want_q.second_source_reg,
                    result_o.second_source_reg);
        check_field("target_reg", want_q.target_reg, result_o.target_reg);
        check_field("target_discard", want_q.target_discard, result_o.target_discard);
        check_field("slot_is_imm", want_q.slot_is_imm, result_o.slot_is_imm);
        check_field("first_source_imm", want_q.first_source_imm, result_o.first_source_imm);
        check_field("second_source_imm", want_q.second_source_imm,
                    result_o.second_source_imm);
        check_field("target_imm", want_q.target_imm, result_o.target_imm);
      end
    end
  end

  // Each supported operation once, with random free fields
  task automatic test_every_operation();
    for (int op = 1; op <= 64; op++) issue_instr(encode_op(op_e'(op)), pick_pc());
  endtask

  // All-zero and all-one words and addresses, immediate sign edges, the largest shift amount
  task automatic test_field_extremes();
    logic [31:0] w;
    issue_instr(32'h0000_0000, 32'h0000_0000);
    issue_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    w = encode_op(OP_ADDI); w[15:0] = 16'h8000; issue_instr(w, 32'h0000_0000);
    w = encode_op(OP_ORI);  w[15:0] = 16'hFFFF; issue_instr(w, 32'hFFFF_FFFF);
    w = encode_op(OP_LUI);  w[15:0] = 16'hFFFF; issue_instr(w, pick_pc());
    w = encode_op(OP_SLLI); w[10:6] = 5'h1F;    issue_instr(w, pick_pc());
  endtask

  // Holes in each decode table give operation zero and empty slots
  task automatic test_invalid_encodings();
    logic [31:0] w;
    w = encode_op(OP_ADD); w[5:0] = 6'd1; issue_instr(w, pick_pc());
    w = encode_op(OP_BLTZ); w[20:16] = RT_BGEZ + 5'd1; issue_instr(w, pick_pc());
    w = encode_op(OP_MFC0); w[25:21] = RS_MF + 5'd1; issue_instr(w, pick_pc());
    w = encode_op(OP_TLBP); w[5:0] = CO_TLBP + 6'd1; issue_instr(w, pick_pc());
    w = encode_op(OP_MUL); w[5:0] = 6'd0; issue_instr(w, pick_pc());
    w = $urandom; w[31:26] = OPC_ADDI - 6'd1; issue_instr(w, pick_pc());
  endtask

  // r0 as destination: flagged only when written and not read
  task automatic test_zero_target();
    logic [31:0] w;
    w = encode_op(OP_ADD);  w[15:11] = REG_ZERO; issue_instr(w, pick_pc());
    w = encode_op(OP_SRAI); w[15:11] = REG_ZERO; issue_instr(w, pick_pc());
    w = encode_op(OP_JALR); w[15:11] = REG_ZERO; issue_instr(w, pick_pc());
    w = encode_op(OP_MOVZ); w[15:11] = REG_ZERO; issue_instr(w, pick_pc());
    w = encode_op(OP_LW);   w[20:16] = REG_ZERO; issue_instr(w, pick_pc());
    w = encode_op(OP_LWL);  w[20:16] = REG_ZERO; issue_instr(w, pick_pc());
    w = encode_op(OP_SW);   w[20:16] = REG_ZERO; issue_instr(w, pick_pc());
    w = encode_op(OP_XORI); w[20:16] = REG_ZERO; issue_instr(w, pick_pc());
    w = encode_op(OP_LUI);  w[20:16] = REG_ZERO; issue_instr(w, pick_pc());
    w = encode_op(OP_MFC0); w[20:16] = REG_ZERO; issue_instr(w, pick_pc());
  endtask

  // Link and target addresses that wrap round either end of the address space, plus jump edge cases
  task automatic test_address_wrap();
    logic [31:0] w;
    issue_instr(encode_op(OP_JAL), 32'hFFFF_FFFC);
    issue_instr(encode_op(OP_JALR), 32'hFFFF_FFF8);
    w = encode_op(OP_BEQ);  w[15:0] = 16'h7FFF; issue_instr(w, 32'hFFFF_FFFC);
    w = encode_op(OP_BNE);  w[15:0] = 16'h8000; issue_instr(w, 32'h0000_0000);
    w = encode_op(OP_BGEZ); w[15:0] = 16'hFFFF; issue_instr(w, 32'h0000_0000);
    w = encode_op(OP_J);    w[25:0] = '1;       issue_instr(w, 32'hF000_0000);
    w = encode_op(OP_JR);   w[25:21] = REG_ZERO; issue_instr(w, pick_pc());
  endtask

  // Mostly well-formed operations with random fields, the rest raw noise
  task automatic test_random_stream();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 85)
        issue_instr(encode_op(op_e'($urandom_range(1, 64))), pick_pc());
      else
        issue_instr($urandom, pick_pc());
    end
  endtask

  // Run-away guard
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence
  initial begin
    mismatch_count = 0;
    burst_left     = 0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    item_i         = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_every_operation();
    test_field_extremes();
    test_invalid_encodings();
    test_zero_target();
    test_address_wrap();
    test_random_stream();

    // Drain: wait until every prediction is matched, plus a little margin
    start_i <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
